// ----- src/trs_pkg.sv -----
// Shared types and constants for the TLV record scanner.
`timescale 1ns / 1ps
package trs_pkg;

   localparam int unsigned HDR_BYTES   = 8;
   localparam int unsigned VALUE_BYTES = 4;

   localparam int unsigned EV_W   = 3;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PH_W   = 2;
   localparam int unsigned CNT_W  = $clog2(HDR_BYTES);

   localparam logic [CNT_W-1:0]  HDR_LAST  = CNT_W'(HDR_BYTES - 1);
   localparam logic [WORD_W-1:0] VALUE_LEN = WORD_W'(VALUE_BYTES);

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [PH_W-1:0] PH_HEADER  = 2'd0;
   localparam logic [PH_W-1:0] PH_PAYLOAD = 2'd1;
   localparam logic [PH_W-1:0] PH_DONE    = 2'd2;

   localparam logic [EV_W-1:0] EV_HEADER    = 3'd0;
   localparam logic [EV_W-1:0] EV_FOUND     = 3'd1;
   localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd2;
   localparam logic [EV_W-1:0] EV_TRUNC_HDR = 3'd3;
   localparam logic [EV_W-1:0] EV_TRUNC_PAY = 3'd4;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [WORD_W-1:0] record_tag;
      logic [WORD_W-1:0] record_length;
      logic [WORD_W-1:0] found_value;
   } rsp_type;

   typedef struct packed {
      logic    go;
      logic    res_vld;
      rsp_type res;
   } res_ctl_type;

endpackage

// ----- src/trs_if.sv -----
// Valid/ready channel interfaces for the scanner's request and response beats.
`timescale 1ns / 1ps
interface trs_req_if;
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [trs_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface trs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [trs_pkg::EV_W-1:0]   event_res;
   logic [trs_pkg::WORD_W-1:0] record_tag;
   logic [trs_pkg::WORD_W-1:0] record_length;
   logic [trs_pkg::WORD_W-1:0] found_value;

   modport source (output valid, output event_res, output record_tag,
                   output record_length, output found_value, input ready);
   modport sink   (input valid, input event_res, input record_tag,
                   input record_length, input found_value, output ready);
endinterface

// ----- src/trs_in_stage.sv -----
// Input register holding one accepted request beat.
`timescale 1ns / 1ps
module trs_in_stage (
   input  logic             clock,
   input  logic             reset,
   trs_req_if.sink          req_ch,
   input  logic             go,
   output logic             in_valid,
   output trs_pkg::req_type in_beat
);
   import trs_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_beat_ff;
   logic    take;

   assign req_ch.ready = !in_valid_ff || go;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_beat_ff <= '{command: req_ch.command, data_byte: req_ch.data_byte};
      end
   end

   assign in_valid = in_valid_ff;
   assign in_beat  = in_beat_ff;

endmodule

// ----- src/trs_parser.sv -----
// Record parsing state and the per-beat update of header, payload and capture.
`timescale 1ns / 1ps
module trs_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [trs_pkg::WORD_W-1:0] sought_tag,
   input  logic                       go,
   input  trs_pkg::req_type           in_beat,
   output trs_pkg::res_ctl_type       res_ctl
);
   import trs_pkg::*;

   logic [PH_W-1:0]     phase_ff, phase_in;
   logic [CNT_W-1:0]    hdr_count_ff, hdr_count_in;
   logic [2*WORD_W-1:0] hdr_shift_ff, hdr_shift_in;
   logic [WORD_W-1:0]   pay_left_ff, pay_left_in;
   logic                armed_ff, armed_in;
   logic [WORD_W-1:0]   value_ff, value_in;
   logic [WORD_W-1:0]   tag, len;
   logic                res_vld;
   rsp_type             res;

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      hdr_shift_in = hdr_shift_ff;
      pay_left_in  = pay_left_ff;
      armed_in     = armed_ff;
      value_in     = value_ff;
      res_vld      = 1'b0;
      res          = '0;
      tag          = hdr_shift_in[WORD_W-1:0];
      len          = hdr_shift_in[2*WORD_W-1:WORD_W];
      if (go) begin
         if (in_beat.command == CMD_END) begin
            res_vld = 1'b1;
            case (phase_ff)
               PH_HEADER: begin
                  res.event_res = (hdr_count_ff != '0) ? EV_TRUNC_HDR : EV_NOT_FOUND;
               end
               PH_PAYLOAD: begin
                  res.event_res = EV_TRUNC_PAY;
               end
               default: begin
                  res.event_res   = EV_FOUND;
                  res.found_value = value_ff;
               end
            endcase
            phase_in     = PH_HEADER;
            hdr_count_in = '0;
            hdr_shift_in = '0;
            pay_left_in  = '0;
            armed_in     = 1'b0;
            value_in     = '0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  hdr_shift_in = {in_beat.data_byte, hdr_shift_ff[2*WORD_W-1:BYTE_W]};
                  hdr_count_in = hdr_count_ff + 1'b1;
                  tag          = hdr_shift_in[WORD_W-1:0];
                  len          = hdr_shift_in[2*WORD_W-1:WORD_W];
                  if (hdr_count_ff == HDR_LAST) begin
                     hdr_shift_in      = '0;
                     pay_left_in       = len;
                     armed_in          = (tag == sought_tag) && (len == VALUE_LEN);
                     value_in          = '0;
                     res_vld           = 1'b1;
                     res.event_res     = EV_HEADER;
                     res.record_tag    = tag;
                     res.record_length = len;
                     if (len != '0) begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  if (armed_ff) begin
                     value_in = {in_beat.data_byte, value_ff[WORD_W-1:BYTE_W]};
                  end
                  pay_left_in = pay_left_ff - 1'b1;
                  if (pay_left_in == '0) begin
                     phase_in = armed_ff ? PH_DONE : PH_HEADER;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_count_ff <= '0;
         hdr_shift_ff <= '0;
         pay_left_ff  <= '0;
         armed_ff     <= 1'b0;
         value_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         hdr_shift_ff <= hdr_shift_in;
         pay_left_ff  <= pay_left_in;
         armed_ff     <= armed_in;
         value_ff     <= value_in;
      end
   end

   assign res_ctl = '{go: go, res_vld: res_vld, res: res};

endmodule

// ----- src/trs_out_stage.sv -----
// Result register driving the response channel.
`timescale 1ns / 1ps
module trs_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  trs_pkg::res_ctl_type res_ctl,
   output logic                 busy,
   trs_rsp_if.source            rsp_ch
);
   import trs_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   logic    load;

   assign load = res_ctl.go && res_ctl.res_vld;

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= res_ctl.res;
      end
   end

   assign busy                 = out_valid_ff && !rsp_ch.ready;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.event_res     = out_ff.event_res;
   assign rsp_ch.record_tag    = out_ff.record_tag;
   assign rsp_ch.record_length = out_ff.record_length;
   assign rsp_ch.found_value   = out_ff.found_value;

endmodule

// ----- src/tlv_record_scanner.sv -----
// Top level of the TLV record scanner.
//
// Request channel: one beat per blob byte (command 0, data_byte) or an end
// command (command 1). Records are a 4-byte tag and 4-byte length, both
// little-endian, then the payload. Response channel: one beat per parsed
// header (event 0 with tag and length) and one beat per end command
// (found with value, not found, truncated header or truncated payload).
// csr_we/csr_wdata load the sought tag; write it only while idle.
// A beat is registered at acceptance and parsed when it leaves the input
// register, its result landing in the result register; a stalled
// receiver can hold it in between. One beat per cycle is sustained while
// the receiver is ready, set by the combinational parse between the registers.
// Reset clears the parse state, the sought tag and both valid flags.
// While the receiver stalls with a result waiting, the input register
// holds and the request side stops after at most one more beat.
`timescale 1ns / 1ps
module tlv_record_scanner (
   input  logic                       clock,
   input  logic                       reset,
   trs_req_if.sink                    req_ch,
   trs_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [trs_pkg::WORD_W-1:0] csr_wdata
);
   import trs_pkg::*;

   logic [WORD_W-1:0] sought_tag_ff;
   logic              in_valid;
   req_type           in_beat;
   logic              busy;
   logic              go;
   res_ctl_type       res_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         sought_tag_ff <= '0;
      end else if (csr_we) begin
         sought_tag_ff <= csr_wdata;
      end
   end

   assign go = in_valid && !busy;

   trs_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .go       (go),
      .in_valid (in_valid),
      .in_beat  (in_beat)
   );

   trs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .sought_tag (sought_tag_ff),
      .go         (go),
      .in_beat    (in_beat),
      .res_ctl    (res_ctl)
   );

   trs_out_stage u_out (
      .clock   (clock),
      .reset   (reset),
      .res_ctl (res_ctl),
      .busy    (busy),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the TLV record scanner: directed and random blobs under stalls.
`timescale 1ns / 1ps
module tb_top;
   import trs_pkg::*;

   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned PHASE_BEATS   = 75;
   localparam int unsigned PHASES        = 6;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned MAX_WAIT      = 19;

   class tlv_scoreboard;
      logic [WORD_W-1:0]   sought_tag;
      logic [PH_W-1:0]     phase;
      logic [CNT_W-1:0]    hdr_count;
      logic [2*WORD_W-1:0] hdr_shift;
      logic [WORD_W-1:0]   pay_left;
      bit                  armed;
      logic [WORD_W-1:0]   value_shift;
      rsp_type             expected_events[$];
      int                  errors;
      int unsigned         live_beats;

      function new();
         sought_tag = '0;
         errors     = 0;
         live_beats = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase       = PH_HEADER;
         hdr_count   = '0;
         hdr_shift   = '0;
         pay_left    = '0;
         armed       = 1'b0;
         value_shift = '0;
      endfunction

      // predict the outcome of one accepted request beat
      function void take_beat(logic cmd, logic [BYTE_W-1:0] b);
         rsp_type ev;
         ev = '0;
         if (cmd == CMD_END) begin
            live_beats++;
            if (phase >= PH_DONE) begin
               ev.event_res   = EV_FOUND;
               ev.found_value = value_shift;
            end else if (phase == PH_PAYLOAD) begin
               ev.event_res = EV_TRUNC_PAY;
            end else if (hdr_count != '0) begin
               ev.event_res = EV_TRUNC_HDR;
            end else begin
               ev.event_res = EV_NOT_FOUND;
            end
            expected_events = {expected_events, ev};
            clear_parse();
         end else if (phase == PH_HEADER) begin
            live_beats++;
            hdr_shift = {b, hdr_shift[2*WORD_W-1:BYTE_W]};
            hdr_count = hdr_count + 1'b1;
            if (hdr_count == '0) begin
               ev.event_res     = EV_HEADER;
               ev.record_tag    = hdr_shift[WORD_W-1:0];
               ev.record_length = hdr_shift[2*WORD_W-1:WORD_W];
               hdr_shift        = '0;
               pay_left         = ev.record_length;
               armed            = (ev.record_tag == sought_tag) &&
                                  (ev.record_length == VALUE_LEN);
               value_shift      = '0;
               if (ev.record_length != '0) phase = PH_PAYLOAD;
               expected_events = {expected_events, ev};
            end
         end else if (phase == PH_PAYLOAD) begin
            live_beats++;
            if (armed) value_shift = {b, value_shift[WORD_W-1:BYTE_W]};
            pay_left = pay_left - 1'b1;
            if (pay_left == '0) phase = armed ? PH_DONE : PH_HEADER;
         end
      endfunction

      function void check_field(string field, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: result with none pending: event %0d tag %h len %h value %h",
                     $time, got.event_res, got.record_tag, got.record_length,
                     got.found_value);
            return;
         end
         want = expected_events.pop_front();
         check_field("event_res", WORD_W'(want.event_res), WORD_W'(got.event_res));
         check_field("record_tag", want.record_tag, got.record_tag);
         check_field("record_length", want.record_length, got.record_length);
         check_field("found_value", want.found_value, got.found_value);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [WORD_W-1:0] csr_wdata;

   trs_req_if req_bus ();
   trs_rsp_if rsp_bus ();

   tlv_record_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   tlv_scoreboard sb;
   rsp_type       seen_result;
   bit            calm     = 1'b0;
   bit            hold_req = 1'b0;
   int unsigned   idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor both channels
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.take_beat(req_bus.command, req_bus.data_byte);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen_result.event_res     = rsp_bus.event_res;
            seen_result.record_tag    = rsp_bus.record_tag;
            seen_result.record_length = rsp_bus.record_length;
            seen_result.found_value   = rsp_bus.found_value;
            sb.match_result(seen_result);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** tlv_record_scanner: FAILED **");
            $finish;
         end
      end
   end

   // response side: random stalls, one long hold on request
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock) rsp_bus.ready <= 1'b0;
         end
         stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
         repeat (stall) @(negedge clock) rsp_bus.ready <= 1'b0;
         @(negedge clock) rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   task automatic send_beat(input logic cmd, input logic [BYTE_W-1:0] b);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (gap) @(negedge clock) req_bus.valid <= 1'b0;
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.data_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_header(input logic [WORD_W-1:0] tag, input logic [WORD_W-1:0] len);
      for (int i = 0; i < 4; i++) send_beat(CMD_BYTE, tag[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_beat(CMD_BYTE, len[8*i +: 8]);
   endtask

   // drop valid and wait for every pending result
   task automatic drain();
      @(negedge clock) req_bus.valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_tag(input logic [WORD_W-1:0] t);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= t;
      @(negedge clock) csr_we <= 1'b0;
      sb.sought_tag = t;
   endtask

   task automatic send_blob();
      logic [BYTE_W-1:0] blob[$];
      logic [WORD_W-1:0] tag;
      logic [WORD_W-1:0] len;
      int unsigned       nrec;
      int unsigned       pick;
      int unsigned       count;
      int unsigned       cut;
      bit                long_rec;
      long_rec = 1'b0;
      nrec     = $urandom_range(0, 4);
      for (int r = 0; r < nrec && !long_rec; r++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)      tag = sb.sought_tag;
         else if (pick < 75) tag = $urandom;
         else                tag = sb.sought_tag ^ (32'h1 << $urandom_range(0, 31));
         pick = $urandom_range(0, 99);
         if (pick < 40)      len = VALUE_LEN;
         else if (pick < 60) len = '0;
         else if (pick < 92) len = $urandom_range(1, 8);
         else if (pick < 96) len = 32'hFFFF_FFFF;
         else                len = $urandom | 32'h100;
         long_rec = (len > 8);
         count    = long_rec ? $urandom_range(0, 6) : len;
         for (int i = 0; i < 4; i++) blob = {blob, tag[8*i +: 8]};
         for (int i = 0; i < 4; i++) blob = {blob, len[8*i +: 8]};
         repeat (count) blob = {blob, BYTE_W'($urandom_range(0, 255))};
      end
      repeat ($urandom_range(0, 3)) blob = {blob, BYTE_W'($urandom_range(0, 255))};
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
         blob.delete();
         repeat ($urandom_range(1, 20)) blob = {blob, BYTE_W'($urandom_range(0, 255))};
      end else if (pick >= 70) begin
         cut = $urandom_range(0, blob.size());
         while (blob.size() > cut) void'(blob.pop_back());
      end
      foreach (blob[i]) send_beat(CMD_BYTE, blob[i]);
      send_beat(CMD_END, BYTE_W'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [WORD_W-1:0] phase_tag;
      int unsigned       target;
      int unsigned       blob_no;
      sb                 = new();
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= CMD_BYTE;
      req_bus.data_byte <= '0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      write_tag(32'hFFFF_FFFF);
      // empty blob
      send_beat(CMD_END, 8'hFF);
      // partial header
      send_beat(CMD_BYTE, 8'h00);
      send_beat(CMD_BYTE, 8'hFF);
      send_beat(CMD_BYTE, 8'h5A);
      send_beat(CMD_END, 8'h00);
      // capture, then a byte that must be ignored
      send_header(32'hFFFF_FFFF, VALUE_LEN);
      send_beat(CMD_BYTE, 8'h00);
      send_beat(CMD_BYTE, 8'hFF);
      send_beat(CMD_BYTE, 8'h81);
      send_beat(CMD_BYTE, 8'h7E);
      send_beat(CMD_BYTE, 8'hA5);
      send_beat(CMD_END, 8'h00);
      // matching tag with the longest length, cut short
      send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_BYTE, 8'h3C);
      send_beat(CMD_END, 8'h00);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)      phase_tag = '0;
         else if (ph == 1) phase_tag = 32'hFFFF_FFFF;
         else              phase_tag = $urandom;
         write_tag(phase_tag);
         target  = sb.live_beats + PHASE_BEATS;
         blob_no = 0;
         while (sb.live_beats < target) begin
            calm = ($urandom_range(0, 4) == 0);
            if (ph == 2 && blob_no == 1) begin
               // hold the response side while zero-length headers pile up
               calm     = 1'b1;
               hold_req = 1'b1;
               repeat (12) send_header($urandom, '0);
               send_beat(CMD_END, 8'h00);
            end else begin
               send_blob();
            end
            if ($urandom_range(0, 7) == 0) drain();
            blob_no++;
         end
         calm = 1'b0;
         drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_events.size() == 0) begin
         $display("** tlv_record_scanner: PASSED **");
      end else begin
         $display("** tlv_record_scanner: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/trs_pkg.sv
src/trs_if.sv
src/trs_in_stage.sv
src/trs_parser.sv
src/trs_out_stage.sv
src/tlv_record_scanner.sv
verif/tb_top.sv
